// ===== sv/swmd_pkg.sv =====
package swmd_pkg;

	localparam int WINDOW_MAX   = 256;
	localparam int SAMPLE_WIDTH = 32;
	localparam int IDX_W        = $clog2(WINDOW_MAX);
	localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
	localparam int COST_W       = 40;
	localparam int ACC_W        = SAMPLE_WIDTH + IDX_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic remove;
		logic insert;
		logic scan_step;
		logic finish;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic will_result;
		logic scan_last;
	} status_t;

endpackage

// ===== sv/swmd_ctrl.sv =====
module swmd_ctrl import swmd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// state and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.cfg_wr    = cfg_valid;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.full ? ST_REMOVE : ST_INSERT;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = status.will_result ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

endmodule

// ===== sv/swmd_datapath.sv =====
module swmd_datapath import swmd_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	input  logic [CNT_W-1:0]               cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output status_t                        status,
	output logic [COST_W-1:0]              cost_out,
	output logic signed [SAMPLE_WIDTH-1:0] median_out
);

	logic [CNT_W-1:0]               k_q, k_eff, fill_q, ins_cnt, mid_idx, idx_q;
	logic [IDX_W-1:0]               ptr_q, wr_addr;
	logic                           full;
	logic signed [SAMPLE_WIDTH-1:0] sample_q, old_q, med_q, x;
	logic signed [SAMPLE_WIDTH-1:0] ring_q [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] cell_q [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] scan_q [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] ins_val [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] rem_val [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]          le;
	logic signed [ACC_W-1:0]        acc_q, x_ext, med_ext;
	logic [COST_W-1:0]              cost_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;

	// effective window size
	always_comb begin
		k_eff = k_q;
		if (k_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (k_q > CNT_W'(WINDOW_MAX)) begin
			k_eff = CNT_W'(WINDOW_MAX);
		end
	end

	assign full               = (fill_q == k_eff);
	assign ins_cnt            = full ? (k_eff - CNT_W'(1)) : fill_q;
	assign wr_addr            = full ? ptr_q : fill_q[IDX_W-1:0];
	assign mid_idx            = (k_eff - CNT_W'(1)) >> 1;
	assign status.full        = full;
	assign status.will_result = full || ((fill_q + CNT_W'(1)) == k_eff);
	assign status.scan_last   = (idx_q == (k_eff - CNT_W'(1)));

	// window size, fill count and oldest pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= CNT_W'(1);
			fill_q <= '0;
			ptr_q  <= '0;
		end else if (cmd.cfg_wr) begin
			k_q    <= cfg_data;
			fill_q <= '0;
			ptr_q  <= '0;
		end else if (cmd.insert) begin
			if (!full) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (({1'b0, ptr_q} + CNT_W'(1)) >= k_eff) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// latch sample, arrival ring write and registered read of the oldest
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_in;
			old_q    <= ring_q[ptr_q];
		end
		if (cmd.insert) begin
			ring_q[wr_addr] <= sample_q;
		end
	end

	// insertion: each cell keeps, takes the new sample, or takes its left neighbor
	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			le[i] = (CNT_W'(i) < ins_cnt) && (cell_q[i] <= sample_q);
		end
		ins_val[0] = le[0] ? cell_q[0] : sample_q;
		for (int i = 1; i < WINDOW_MAX; i++) begin
			if (le[i]) begin
				ins_val[i] = cell_q[i];
			end else if (le[i-1]) begin
				ins_val[i] = sample_q;
			end else begin
				ins_val[i] = cell_q[i-1];
			end
		end
	end

	// removal: cells from the last copy of the old value onward shift down
	always_comb begin
		for (int i = 0; i < WINDOW_MAX - 1; i++) begin
			if ((CNT_W'(i + 1) >= k_eff) || (cell_q[i+1] > old_q)) begin
				rem_val[i] = cell_q[i+1];
			end else begin
				rem_val[i] = cell_q[i];
			end
		end
		rem_val[WINDOW_MAX-1] = cell_q[WINDOW_MAX-1];
	end

	// sorted cells and scan line
	always_ff @(posedge clk) begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (cmd.remove) begin
				cell_q[i] <= rem_val[i];
			end else if (cmd.insert) begin
				cell_q[i] <= ins_val[i];
			end
		end
		if (cmd.insert) begin
			for (int i = 0; i < WINDOW_MAX; i++) begin
				scan_q[i] <= ins_val[i];
			end
		end else if (cmd.scan_step) begin
			for (int i = 0; i < WINDOW_MAX - 1; i++) begin
				scan_q[i] <= scan_q[i+1];
			end
		end
	end

	assign x       = scan_q[0];
	assign x_ext   = ACC_W'(x);
	assign med_ext = ACC_W'(med_q);

	// accumulate: subtract below the median, add above, capture the median
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			acc_q <= '0;
			med_q <= '0;
		end else if (cmd.insert) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CNT_W'(1);
			if (idx_q < mid_idx) begin
				acc_q <= acc_q - x_ext;
			end else if (idx_q == mid_idx) begin
				med_q <= x;
			end else begin
				acc_q <= acc_q + x_ext;
			end
		end
	end

	// result register; an even window has one more value above than below
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			cost_q   <= COST_W'(k_eff[0] ? acc_q : (acc_q - med_ext));
			median_q <= med_q;
		end
	end

	assign cost_out   = cost_q;
	assign median_out = median_q;

endmodule

// ===== sv/sliding_window_median_deviation_sum_core.sv =====
// Sliding-window median and absolute deviation sum.
// Input channel: sample with in_valid/in_stall; an item moves when in_valid
// is high and in_stall low. Output channel: cost and median with
// out_valid/out_stall, same rule. Config channel: window_size with
// cfg_valid/cfg_ready (always ready); a write empties the window. Write it
// only while the block is idle.
// No result appears until window_size samples have been taken; after that
// every sample gives one result: the lower median and the sum of absolute
// differences from it.
// Sequence: a sample that does not complete the window is loaded in IDLE and
// inserted in INSERT. A sample that gives a result passes IDLE, REMOVE (only
// when the window is full) and INSERT, then SCAN walks the sorted cell chain
// and FINISH loads the output register once it is free. The scan length sets
// the rate.
// The next item is accepted while a result waits; a stalled result holds
// and the following result waits behind it.
// Reset clears the window, sets window_size to 1 and drops any result.
module sliding_window_median_deviation_sum_core import swmd_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [COST_W-1:0]              cost,
	output logic signed [SAMPLE_WIDTH-1:0] median,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CNT_W-1:0]               window_size
);

	cmd_t    cmd;
	status_t status;

	swmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	swmd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_data   (window_size),
		.sample_in  (sample),
		.status     (status),
		.cost_out   (cost),
		.median_out (median)
	);

endmodule

// ===== test/tb_sliding_window_median_deviation_sum_core.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_median_deviation_sum_core;
	import swmd_pkg::*;

	localparam int IDLE_WAIT  = 2 * WINDOW_MAX + 40;
	localparam int STALL_LIMIT = 20000;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           out_valid;
	logic                           out_stall;
	logic [COST_W-1:0]              cost;
	logic signed [SAMPLE_WIDTH-1:0] median;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [CNT_W-1:0]               window_size;

	typedef struct {
		logic [COST_W-1:0]              cost;
		logic signed [SAMPLE_WIDTH-1:0] median;
	} window_stat_t;

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] value;
		bit                             has_known;
		logic [COST_W-1:0]              known_cost;
		logic signed [SAMPLE_WIDTH-1:0] known_median;
	} sample_row_t;

	// predictor state
	int                             win_k;
	int                             held;
	int                             oldest;
	logic signed [SAMPLE_WIDTH-1:0] arrivals[WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] ordered[$];

	window_stat_t pending_stats[$];
	bit           failed;
	int           quiet_cycles;
	int           results_seen;

	sliding_window_median_deviation_sum_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall), .cost(cost), .median(median),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_size(window_size)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// no gap mostly, short ones often, long ones now and then
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void window_clear(int raw);
		win_k = raw;
		if (win_k == 0) win_k = 1;
		if (win_k > WINDOW_MAX) win_k = WINDOW_MAX;
		held   = 0;
		oldest = 0;
		ordered.delete();
	endfunction

	function automatic void ordered_add(logic signed [SAMPLE_WIDTH-1:0] v);
		int i;
		i = 0;
		while (i < ordered.size() && ordered[i] <= v) i++;
		ordered.insert(i, v);
	endfunction

	// advance the window by one sample; return 1 with the stat when a result is due
	function automatic bit window_push(logic signed [SAMPLE_WIDTH-1:0] v,
			output window_stat_t stat);
		longint mid;
		longint acc;
		int i;
		stat.cost = '0;
		stat.median = '0;
		if (held < win_k) begin
			arrivals[held] = v;
			ordered_add(v);
			held++;
			if (held < win_k) return 0;
		end else begin
			for (i = 0; i < ordered.size(); i++)
				if (ordered[i] == arrivals[oldest]) begin
					ordered.delete(i);
					break;
				end
			ordered_add(v);
			arrivals[oldest] = v;
			oldest = (oldest + 1 >= win_k) ? 0 : oldest + 1;
		end
		mid = ordered[(win_k - 1) / 2];
		acc = 0;
		foreach (ordered[j])
			acc += (ordered[j] >= mid) ? ordered[j] - mid : mid - ordered[j];
		stat.cost = acc[COST_W-1:0];
		stat.median = mid[SAMPLE_WIDTH-1:0];
		return 1;
	endfunction

	// starts and ends at a falling edge; valid stays up when no gap follows
	task automatic send_sample(sample_row_t row);
		window_stat_t stat;
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= row.value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (window_push(row.value, stat)) begin
			if (row.has_known) begin
				stat.cost = row.known_cost;
				stat.median = row.known_median;
			end
			pending_stats.insert(pending_stats.size(), stat);
		end
		@(negedge clk);
	endtask

	// hold until every expected result is back, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic write_window(int raw);
		drain_results();
		cfg_valid   <= 1'b1;
		window_size <= raw[CNT_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		window_clear(raw);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $signed(32'h8000_0000 + $urandom_range(0, 3));
			1: return $signed(32'h7FFF_FFFC + $urandom_range(0, 3));
			2: return $signed($urandom_range(0, 20)) - 10;
			default: return $signed($urandom());
		endcase
	endfunction

	// output side: random stall, compare against the oldest expectation
	initial begin
		int gap;
		window_stat_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = pick_gap();
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
			if (pending_stats.size() == 0) begin
				$error("unexpected result cost=%0d median=%0d", cost, median);
				failed = 1'b1;
			end else begin
				want = pending_stats.pop_front();
				if (cost !== want.cost) begin
					$error("cost: expected %0d, got %0d", want.cost, cost);
					failed = 1'b1;
				end
				if (median !== want.median) begin
					$error("median: expected %0d, got %0d", want.median, median);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on any channel
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		sample_row_t rows[$];
		sample_row_t row;
		int n;
		int p;
		failed       = 1'b0;
		results_seen = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		window_size  = '0;
		window_clear(1);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset the window holds one sample: median is the sample, cost zero
		rows = '{
			'{32'sh8000_0000, 1, 40'd0, 32'sh8000_0000},
			'{32'sh7FFF_FFFF, 1, 40'd0, 32'sh7FFF_FFFF},
			'{32'sd0,         1, 40'd0, 32'sd0},
			'{-32'sd1,        1, 40'd0, -32'sd1},
			'{32'sh5555_5555, 1, 40'd0, 32'sh5555_5555},
			'{32'shAAAA_AAAA, 1, 40'd0, 32'shAAAA_AAAA}
		};
		foreach (rows[i]) send_sample(rows[i]);

		// two extremes: lower median is the minimum, cost the full span
		write_window(2);
		rows = '{
			'{32'sh8000_0000, 0, '0, '0},
			'{32'sh7FFF_FFFF, 1, 40'hFF_FFFF_FFFF >> 8, 32'sh8000_0000},
			'{32'sh8000_0000, 1, 40'hFF_FFFF_FFFF >> 8, 32'sh8000_0000}
		};
		foreach (rows[i]) send_sample(rows[i]);

		// zero is taken as one; above the limit saturates; duplicates in the window
		write_window(0);
		row = '{32'sd7, 0, '0, '0};
		send_sample(row);
		write_window(511);
		for (int i = 0; i < WINDOW_MAX + 4; i++) begin
			row.value = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			send_sample(row);
		end
		write_window(3);
		for (int i = 0; i < 6; i++) begin
			row.value = (i < 4) ? 32'sd5 : -32'sd5;
			send_sample(row);
		end

		// random phases, mostly small windows
		n = 0;
		p = 0;
		while (n < 2000) begin
			case ($urandom_range(0, 9))
				0: write_window($urandom_range(0, 511));
				1: write_window(WINDOW_MAX);
				default: write_window($urandom_range(1, 9));
			endcase
			for (int i = 0; i < $urandom_range(win_k, win_k + 60); i++) begin
				row.value = rand_value();
				send_sample(row);
				n++;
				if ($urandom_range(0, 99) == 0) drain_results();
			end
			p++;
		end

		drain_results();
		if (!failed && pending_stats.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/swmd_pkg.sv
sv/swmd_ctrl.sv
sv/swmd_datapath.sv
sv/sliding_window_median_deviation_sum_core.sv
test/tb_sliding_window_median_deviation_sum_core.sv
